>>> rtl/assert_macros.svh
// Assertion helpers shared by the queue, core and divider RTL files.
// Each expects clk and arst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge.
`define MST_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define MST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/mst_pkg.sv
package mst_pkg;

	// Bus clock in MHz, 1 to 255
	localparam int unsigned CLK_MHZ = 66;
	localparam int CLK_W = 8;

	localparam int OP_W      = 2;
	localparam int TS_W      = 32;
	localparam int CNT_W     = 24;
	localparam int OFS_W     = 64;
	localparam int REM_CYC_W = 40;

	localparam logic [CNT_W-1:0] SEG_MAX     = 24'hFFFFFF;
	localparam logic [TS_W-1:0]  LATE_MARGIN = 32'd10;

	// long division by CLK_MHZ, one digit per stage
	localparam int DIG_W      = 8;
	localparam int DIV_STAGES = OFS_W / DIG_W;
	localparam int Q_DIGITS   = TS_W / DIG_W;

	// request queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_SET  = 2'd2;
	localparam logic [OP_W-1:0] OP_OFF  = 2'd3;

	typedef enum logic [1:0] {
		K_TICK,
		K_READ,
		K_SET,
		K_OFF
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [TS_W-1:0] ts;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} q_push_t;

	typedef struct packed {
		logic    avail;
		qentry_t entry;
	} q_rd_t;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic             alarm;
		logic [OFS_W-1:0] cycles;
	} div_req_t;

	typedef struct packed {
		logic            valid;
		logic [TS_W-1:0] now;
	} sa_done_t;

	typedef struct packed {
		logic [CNT_W-1:0]     reload;
		logic [REM_CYC_W-1:0] remaining;
	} seg_t;

	// one restoring-division digit: returns {quotient digit, new remainder}
	function automatic logic [DIG_W+CLK_W-1:0] div_digit(input logic [CLK_W-1:0] rem,
		input logic [DIG_W-1:0] dig);
		logic [CLK_W:0]     acc;
		logic [CLK_W-1:0]   r;
		logic [DIG_W-1:0]   q;
		r = rem;
		q = '0;
		for (int b = DIG_W - 1; b >= 0; b--) begin
			acc = {r, dig[b]};
			if (acc >= (CLK_W + 1)'(CLK_MHZ)) begin
				acc  = acc - (CLK_W + 1)'(CLK_MHZ);
				q[b] = 1'b1;
			end
			r = acc[CLK_W-1:0];
		end
		return {q, r};
	endfunction

	// split a cycle distance into a first segment and what is left over
	function automatic seg_t load_seg(input logic [REM_CYC_W-1:0] c);
		seg_t s;
		if (c > REM_CYC_W'(SEG_MAX)) begin
			s.reload    = SEG_MAX;
			s.remaining = c - REM_CYC_W'(SEG_MAX);
		end else begin
			s.reload    = c[CNT_W-1:0];
			s.remaining = '0;
		end
		return s;
	endfunction

endpackage

>>> rtl/mst_if.sv
interface mst_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] timestamp;

	modport source(output valid, op, timestamp, input ready);
	modport sink(input valid, op, timestamp, output ready);
endinterface

interface mst_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_us;
	logic        alarm;

	modport source(output valid, now_us, alarm, input ready);
	modport sink(input valid, now_us, alarm, output ready);
endinterface

>>> rtl/mst_queue.sv
`include "assert_macros.svh"

module mst_queue import mst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_push_t wr,
	output logic    full,
	input  logic    pop,
	output q_rd_t   rd
);

	qentry_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign rd.avail = (cnt_q != '0);
	assign rd.entry = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr.valid) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(wr.valid) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			mem_q[wr_q] <= wr.entry;
		end
	end

	`MST_ASSERT_IMP(a_q_no_overflow, wr.valid, !full, "request written into a full queue")
	`MST_ASSERT_IMP(a_q_no_underflow, pop, rd.avail, "request popped from an empty queue")

endmodule

>>> rtl/mst_front.sv
module mst_front import mst_pkg::*; (
	mst_cmd_if.sink  cmd,
	input  logic     full,
	output q_push_t  wr
);

	kind_t kind;

	always_comb begin
		case (cmd.op)
			OP_TICK: kind = K_TICK;
			OP_READ: kind = K_READ;
			OP_SET:  kind = K_SET;
			OP_OFF:  kind = K_OFF;
			default: kind = K_TICK;
		endcase
	end

	assign cmd.ready     = !full;
	assign wr.valid      = cmd.valid && !full;
	assign wr.entry.kind = kind;
	// timestamp matters only to set alarm
	assign wr.entry.ts   = (kind == K_SET) ? cmd.timestamp : '0;

endmodule

>>> rtl/mst_core.sv
`include "assert_macros.svh"

module mst_core import mst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_rd_t    qrd,
	output logic     pop,
	input  logic     adv,
	output div_req_t dreq,
	input  sa_done_t sad
);

	typedef enum logic [3:0] {
		ST_RUN  = 4'b0001,
		ST_WAIT = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_LOAD = 4'b1000
	} core_st_t;

	core_st_t             st_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     reload_q;
	logic [OFS_W-1:0]     ofs_q;
	logic [REM_CYC_W-1:0] remc_q;
	logic                 en_q;
	logic [TS_W-1:0]      ts_q;
	logic [TS_W-1:0]      now_q;
	logic [REM_CYC_W-1:0] diff_q;

	logic [OFS_W-1:0]     cycles;
	logic                 wrap;
	logic                 tick_alarm;
	seg_t                 tick_seg;
	seg_t                 mul_seg;
	logic [TS_W-1:0]      now_adj;
	logic [TS_W-1:0]      span_us;
	logic [REM_CYC_W-1:0] prod;

	// elapsed cycles since reset
	assign cycles     = ofs_q + OFS_W'(reload_q) - OFS_W'(cnt_q);
	assign wrap       = (cnt_q <= CNT_W'(1));
	assign tick_alarm = wrap && (remc_q == '0) && en_q;
	assign tick_seg   = load_seg(remc_q);
	assign mul_seg    = load_seg(diff_q);

	// late alarm: pretend we are a fixed margin before it
	assign now_adj = (now_q >= ts_q) ? ts_q - LATE_MARGIN : now_q;
	assign span_us = ts_q - now_adj;
	assign prod    = REM_CYC_W'(span_us) * REM_CYC_W'(CLK_MHZ);

	assign pop         = (st_q == ST_RUN) && qrd.avail && adv;
	assign dreq.valid  = pop;
	assign dreq.kind   = qrd.entry.kind;
	assign dreq.alarm  = (qrd.entry.kind == K_TICK) && tick_alarm;
	assign dreq.cycles = cycles;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_RUN;
			cnt_q    <= SEG_MAX;
			reload_q <= SEG_MAX;
			ofs_q    <= '0;
			remc_q   <= '0;
			en_q     <= 1'b0;
		end else begin
			case (st_q)
				ST_RUN: begin
					if (pop) begin
						case (qrd.entry.kind)
							K_TICK: begin
								if (!wrap) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end else begin
									ofs_q <= ofs_q + OFS_W'(reload_q);
									if (remc_q != '0) begin
										reload_q <= tick_seg.reload;
										remc_q   <= tick_seg.remaining;
										cnt_q    <= tick_seg.reload;
									end else begin
										cnt_q <= reload_q;
									end
								end
							end
							K_READ: ;
							K_SET: st_q <= ST_WAIT;
							K_OFF: begin
								en_q     <= 1'b0;
								reload_q <= SEG_MAX;
							end
							default: ;
						endcase
					end
				end
				ST_WAIT: begin
					if (sad.valid) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: st_q <= ST_LOAD;
				ST_LOAD: begin
					// fold elapsed part of segment into offset, restart counter
					ofs_q    <= cycles;
					reload_q <= mul_seg.reload;
					remc_q   <= mul_seg.remaining;
					cnt_q    <= mul_seg.reload;
					en_q     <= 1'b1;
					st_q     <= ST_RUN;
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (qrd.entry.kind == K_SET)) begin
			ts_q <= qrd.entry.ts;
		end
		if ((st_q == ST_WAIT) && sad.valid) begin
			now_q <= sad.now;
		end
		if (st_q == ST_MUL) begin
			diff_q <= prod;
		end
	end

	`MST_ASSERT_IMP(a_sad_in_wait, sad.valid, st_q == ST_WAIT, "alarm time returned while not waiting")
	`MST_ASSERT(a_cnt_le_reload, cnt_q <= reload_q, "down counter above reload value")

endmodule

>>> rtl/mst_div.sv
`include "assert_macros.svh"

module mst_div import mst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  dreq,
	output logic      adv,
	output sa_done_t  sad,
	mst_res_if.source result
);

	typedef struct packed {
		kind_t            kind;
		logic             alarm;
		logic [OFS_W-1:0] cycles;
		logic [CLK_W-1:0] rem;
		logic [TS_W-1:0]  quo;
	} stage_t;

	localparam int LAST = DIV_STAGES - 1;

	logic [DIV_STAGES-1:0] div_vld_s;
	stage_t                div_s [DIV_STAGES];
	stage_t                nxt [DIV_STAGES];
	logic                  out_vld_q;
	logic [TS_W-1:0]       out_now_q;
	logic                  out_alarm_q;

	// stage k takes digit LAST-k, most significant first
	always_comb begin
		logic [DIG_W-1:0]       dig;
		logic [DIG_W+CLK_W-1:0] dres;
		for (int k = 0; k < DIV_STAGES; k++) begin
			dig        = div_s[k].cycles[(LAST - k) * DIG_W +: DIG_W];
			dres       = div_digit(div_s[k].rem, dig);
			nxt[k]     = div_s[k];
			nxt[k].rem = dres[CLK_W-1:0];
			// upper quotient digits fall outside the 32-bit result
			if ((LAST - k) < Q_DIGITS) begin
				nxt[k].quo[((LAST - k) % Q_DIGITS) * DIG_W +: DIG_W] =
					dres[DIG_W+CLK_W-1:CLK_W];
			end
		end
	end

	assign adv = !out_vld_q || result.ready;

	assign sad.valid = adv && div_vld_s[LAST] && (div_s[LAST].kind == K_SET);
	assign sad.now   = nxt[LAST].quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			div_vld_s <= {div_vld_s[DIV_STAGES-2:0], dreq.valid};
			out_vld_q <= div_vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].kind   <= dreq.kind;
			div_s[0].alarm  <= dreq.alarm;
			div_s[0].cycles <= dreq.cycles;
			div_s[0].rem    <= '0;
			div_s[0].quo    <= '0;
			for (int k = 1; k < DIV_STAGES; k++) begin
				div_s[k] <= nxt[k-1];
			end
			out_now_q   <= (nxt[LAST].kind == K_READ) ? nxt[LAST].quo : '0;
			out_alarm_q <= nxt[LAST].alarm;
		end
	end

	assign result.valid  = out_vld_q;
	assign result.now_us = out_now_q;
	assign result.alarm  = out_alarm_q;

	`MST_ASSERT_IMP(a_alarm_no_time, out_vld_q && out_alarm_q, out_now_q == '0, "alarm on a read result")

endmodule

>>> rtl/microsecond_ticker_with_alarm.sv
// Path: a request goes from the queue through the divider stages to the result register.
// Throughput: tick, read and disable go at one request per cycle unless a result waits,
//   set by the 8-stage divide-by-CLK_MHZ pipeline that every request passes through.
// Set alarm holds the state unit through division, multiply and segment load;
//   the 4-entry request queue keeps accepting meanwhile until it is full.
// Reset (arst_n low, asynchronous): counter and reload to full range, offset and
//   remaining cycles cleared, alarm disarmed, queue and pipeline emptied.
module microsecond_ticker_with_alarm import mst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mst_cmd_if.sink   cmd,
	mst_res_if.source result
);

	// Front: classify each request and park it in a short queue, so that a
	// set alarm in progress does not stop the bus side taking new requests.
	q_push_t  q_wr;
	logic     q_full;
	q_rd_t    q_rd;
	logic     q_pop;

	// Back: the state unit executes requests in order and issues one entry per
	// request into the division pipeline, which also owns the output register.
	logic     div_adv;
	div_req_t div_req;
	sa_done_t sa_done;

	mst_front u_front (
		.cmd  (cmd),
		.full (q_full),
		.wr   (q_wr)
	);

	mst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// Ticks and disables update the counter at once; reads snapshot the cycle
	// count; set alarm waits for its own microsecond value to come back out of
	// the divider before it reloads the counter.
	mst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.qrd    (q_rd),
		.pop    (q_pop),
		.adv    (div_adv),
		.dreq   (div_req),
		.sad    (sa_done)
	);

	// The whole pipeline stalls together while a result waits to be taken.
	mst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.dreq   (div_req),
		.adv    (div_adv),
		.sad    (sa_done),
		.result (result)
	);

endmodule

>>> bench/microsecond_ticker_with_alarm_test.sv
`timescale 1ns / 100ps

module microsecond_ticker_with_alarm_test import mst_pkg::*;;

	localparam int SCRIPT_LEN  = 22;
	localparam int RANDOM_LEN  = 950;
	localparam int TOTAL_REQS  = SCRIPT_LEN + RANDOM_LEN;
	// random part: receiver idles first, then sender, then nobody
	localparam int PHASE_SWAP  = 320;
	localparam int PHASE_CALM  = 640;
	// long receiver hold-off, placed inside the calm phase
	localparam int HOLD_AT     = SCRIPT_LEN + 700;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [OP_W-1:0] op;
		logic [TS_W-1:0] ts;
		bit              pinned;  // expected reading typed in below
		logic [TS_W-1:0] now_us;
		logic            alarm;
	} script_row_t;

	typedef struct {
		logic [TS_W-1:0] now_us;
		logic            alarm;
	} reading_t;

	// kinds of random run
	typedef enum {RUN_ARM, RUN_DISARM, RUN_NOISE} run_t;

	logic clk = 1'b0;
	logic arst_n;

	mst_cmd_if cmd();
	mst_res_if result();

	microsecond_ticker_with_alarm dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Own copy of the timer state, as left by reset.
	logic [CNT_W-1:0]     tk_counter   = SEG_MAX;
	logic [CNT_W-1:0]     tk_reload    = SEG_MAX;
	logic [OFS_W-1:0]     tk_offset    = '0;
	logic [REM_CYC_W-1:0] tk_remaining = '0;
	bit                   tk_armed     = 1'b0;

	reading_t due_readings[$];
	int       faults        = 0;
	int       readings_seen = 0;
	int       send_idle     = 0;
	int       recv_idle     = 0;
	bit       sender_done   = 1'b0;

	// Directed requests: reset state, both ends of the timestamp, every op,
	// a late timestamp, a far-off one that needs several segments, disarming.
	script_row_t script [SCRIPT_LEN] = '{
		'{OP_READ, 32'h0000_0000, 1'b1, 32'd0, 1'b0},
		'{OP_TICK, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_OFF,  32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
		'{OP_SET,  32'h0000_0000, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_TICK, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_TICK, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_READ, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_SET,  32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_TICK, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
		'{OP_SET,  32'hAAAA_AAAA, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'h5555_5555, 1'b0, 32'd0, 1'b0},
		'{OP_OFF,  32'h0000_0000, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_SET,  32'h0000_0001, 1'b1, 32'd0, 1'b0},
		'{OP_TICK, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_TICK, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
		'{OP_READ, 32'h0000_0000, 1'b0, 32'd0, 1'b0},
		'{OP_SET,  32'h0000_0000, 1'b1, 32'd0, 1'b0},
		'{OP_READ, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0}
	};

	// elapsed microseconds: (offset + reload - counter) / CLK_MHZ, low 32 bits
	function automatic logic [TS_W-1:0] ticker_us();
		logic [OFS_W-1:0] cyc;
		cyc = tk_offset + OFS_W'(tk_reload) - OFS_W'(tk_counter);
		return TS_W'(cyc / OFS_W'(CLK_MHZ));
	endfunction

	// next segment is at most a full counter span; the rest waits in remaining
	task automatic take_segment(input logic [OFS_W-1:0] cyc);
		if (cyc > OFS_W'(SEG_MAX)) begin
			tk_reload    = SEG_MAX;
			tk_remaining = REM_CYC_W'(cyc - OFS_W'(SEG_MAX));
		end else begin
			tk_reload    = cyc[CNT_W-1:0];
			tk_remaining = '0;
		end
	endtask

	task automatic advance_ticker(input logic [OP_W-1:0] op, input logic [TS_W-1:0] ts,
		output reading_t r);
		logic [TS_W-1:0] now;
		logic [TS_W-1:0] gap;
		r.now_us = '0;
		r.alarm  = 1'b0;
		case (op)
			OP_TICK: begin
				if (tk_counter > CNT_W'(1)) begin
					tk_counter = tk_counter - CNT_W'(1);
				end else begin
					// wrap: bank the segment, then fire or load the next piece
					tk_offset = tk_offset + OFS_W'(tk_reload);
					if (tk_remaining == '0 && tk_armed)
						r.alarm = 1'b1;
					else if (tk_remaining != '0)
						take_segment(OFS_W'(tk_remaining));
					tk_counter = tk_reload;
				end
			end
			OP_READ: r.now_us = ticker_us();
			OP_SET: begin
				now = ticker_us();
				// already late: pretend we are just short of it
				if (now >= ts)
					now = ts - LATE_MARGIN;
				gap = ts - now;
				tk_offset = tk_offset + OFS_W'(tk_reload) - OFS_W'(tk_counter);
				take_segment(OFS_W'(gap) * OFS_W'(CLK_MHZ));
				tk_counter = tk_reload;
				tk_armed   = 1'b1;
			end
			OP_OFF: begin
				tk_armed  = 1'b0;
				tk_reload = SEG_MAX;
			end
			default: ;
		endcase
	endtask

	task automatic flag_fault(input string what);
		faults++;
		if (faults <= 10)
			$display("%0t: %s", $time, what);
	endtask

	// Reset, then wait for the sender and the last readings.
	initial begin : supervisor
		int waited;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (sender_done);
		waited = 0;
		while (due_readings.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		// idle on so that any stray reading still shows up
		repeat (30) @(posedge clk);
		if (due_readings.size() != 0)
			flag_fault($sformatf("%0d readings never arrived", due_readings.size()));
		if (faults == 0)
			$display("microsecond_ticker_with_alarm test passed");
		else
			$display("microsecond_ticker_with_alarm test failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("microsecond_ticker_with_alarm test failed");
		$finish;
	end

	// Request side. Valid is held until the request is taken; the next one
	// is built only after the predictor has seen the last, so armed runs can
	// aim their timestamp just past the current microsecond count.
	initial begin : request_source
		script_row_t live;
		script_row_t nxt;
		reading_t    got;
		run_t        run_kind;
		int          run_left;
		bit          run_head;
		int          issued;
		int          rnd_idx;
		int          roll;
		logic [TS_W-1:0] now;
		cmd.valid     <= 1'b0;
		cmd.op        <= OP_TICK;
		cmd.timestamp <= '0;
		issued   = 0;
		run_left = 0;
		run_head = 1'b0;
		run_kind = RUN_NOISE;
		wait (arst_n === 1'b1);
		while (!sender_done) begin
			@(posedge clk);
			if (cmd.valid && cmd.ready) begin
				advance_ticker(live.op, live.ts, got);
				if (live.pinned)
					due_readings.push_back('{now_us: live.now_us, alarm: live.alarm});
				else
					due_readings.push_back(got);
			end else if (cmd.valid) begin
				continue;
			end

			rnd_idx = issued - SCRIPT_LEN;
			if (rnd_idx < 0 || rnd_idx >= PHASE_CALM) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (rnd_idx < PHASE_SWAP) begin
				send_idle = 15;
				recv_idle = 83;
			end else begin
				send_idle = 83;
				recv_idle = 15;
			end

			if (issued == TOTAL_REQS) begin
				cmd.valid   <= 1'b0;
				sender_done = 1'b1;
			end else if ((rnd_idx == 0 || rnd_idx == PHASE_SWAP) && due_readings.size() != 0) begin
				// let the block run dry before moving on
				cmd.valid <= 1'b0;
			end else if ($urandom_range(99) < send_idle) begin
				cmd.valid <= 1'b0;
			end else begin
				if (rnd_idx < 0) begin
					nxt = script[issued];
				end else begin
					if (run_left == 0) begin
						roll = $urandom_range(99);
						if (roll < 50)
							run_kind = RUN_ARM;
						else if (roll < 65)
							run_kind = RUN_DISARM;
						else
							run_kind = RUN_NOISE;
						if (run_kind == RUN_NOISE)
							run_left = $urandom_range(16, 4);
						else
							run_left = $urandom_range(260, 70);
						run_head = 1'b1;
					end
					nxt.pinned = 1'b0;
					nxt.now_us = '0;
					nxt.alarm  = 1'b0;
					nxt.ts     = $urandom;
					case (run_kind)
						RUN_ARM: begin
							if (run_head) begin
								// alarm a few us ahead, or late now and then
								nxt.op = OP_SET;
								now = ticker_us();
								if ($urandom_range(4) == 0)
									nxt.ts = now - TS_W'($urandom_range(40));
								else
									nxt.ts = now + TS_W'($urandom_range(3, 1));
							end else if ($urandom_range(11) == 0) begin
								nxt.op = OP_READ;
							end else begin
								nxt.op = OP_TICK;
							end
						end
						RUN_DISARM: begin
							// counter keeps the old reload until its next wrap
							if (run_head)
								nxt.op = OP_OFF;
							else if ($urandom_range(11) == 0)
								nxt.op = OP_READ;
							else
								nxt.op = OP_TICK;
						end
						default: nxt.op = OP_W'($urandom_range(3));
					endcase
					run_head = 1'b0;
					run_left--;
				end
				live = nxt;
				cmd.valid     <= 1'b1;
				cmd.op        <= nxt.op;
				cmd.timestamp <= nxt.ts;
				issued++;
			end
		end
	end

	// Result side ready, with one long hold-off to back up queue and pipeline.
	initial begin : result_sink
		bit held;
		held = 1'b0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && readings_seen >= HOLD_AT) begin
				held = 1'b1;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Each reading must match the oldest outstanding expectation.
	always @(posedge clk) begin : check_readings
		reading_t want;
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			readings_seen++;
			if (due_readings.size() == 0) begin
				flag_fault($sformatf("unexpected reading now_us %0h alarm %0b",
					result.now_us, result.alarm));
			end else begin
				want = due_readings.pop_front();
				if (result.now_us !== want.now_us || result.alarm !== want.alarm)
					flag_fault($sformatf("reading %0d: expected now_us %0h alarm %0b, got now_us %0h alarm %0b",
						readings_seen, want.now_us, want.alarm, result.now_us, result.alarm));
			end
		end
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mst_pkg.sv
rtl/mst_if.sv
rtl/mst_queue.sv
rtl/mst_front.sv
rtl/mst_core.sv
rtl/mst_div.sv
rtl/microsecond_ticker_with_alarm.sv
bench/microsecond_ticker_with_alarm_test.sv
